FILE: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded deque with key search
// Operation codes, status codes, field widths and the default store depth.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Field widths of the command and result beats.
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Default number of entries in the ring store.
  localparam int DEPTH_DEF = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

endpackage

FILE: src/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram: key store of the deque
// One write port and one read port; the read data is registered, so a read
// returns the entry in the cycle after its address is presented.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [bdq_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [bdq_pkg::KEY_W-1:0] rdata
);
  import bdq_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bounded_deque_with_key_search_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_key_search_core: ring-buffer deque with linear key search
// Pushes and pops at either end of a ring store of DEPTH signed keys, finds
// the first key equal to a value counting from the front, and clears.
//
//  Channel   Ports                                         Handshake
//  command   in_op, in_key_value                           start && !busy
//  result    out_status, out_data_out, out_found_position,  out_strobe, one
//            out_entry_count                               cycle, no stall
//
// Sequencing: a push, a clear or an unused code is handled in the idle state
// and its result strobes in the next cycle. A pop reads the store in the idle
// state and registers the key in the pop state. A search reads one entry a
// cycle through the store's single read port and ends on the first hit or
// once the last held entry is compared; a search of an empty deque strobes
// its miss in the next cycle.
// Reset clears the front pointer and the count; the store needs no clearing.
// Exactly one result beat follows each command beat; the receiver cannot
// stall, so a result is never held back.
// ----------------------------------------------------------------------------
module bounded_deque_with_key_search_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdq_pkg::OP_W-1:0]           in_op,
  input  logic signed [bdq_pkg::KEY_W-1:0]   in_key_value,
  output logic                               out_strobe,
  output logic [bdq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bdq_pkg::KEY_W-1:0]   out_data_out,
  output logic [bdq_pkg::POS_W-1:0]          out_found_position,
  output logic [bdq_pkg::COUNT_W-1:0]        out_entry_count
);
  import bdq_pkg::*;

  // Slot index width and count width (the count reaches DEPTH itself).
  localparam int SW = $clog2(DEPTH);
  localparam int CW = SW + 1;

  localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW:0]   DEPTH_EXT = (SW + 1)'(DEPTH);

  // Controller states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POP    = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [SW-1:0]    cmp_pos_r, cmp_pos_nxt;
  logic [SW-1:0]    rd_slot_r, rd_slot_nxt;

  logic                out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0]    out_data_r, out_data_nxt;
  logic [SW-1:0]       out_pos_r, out_pos_nxt;
  logic [CW-1:0]       out_count_r;

  logic             in_accept;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  logic [SW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rdata;

  logic [SW-1:0] front_dec, front_inc, rd_slot_inc;
  logic [SW:0]   back_sum, last_sum;
  logic [SW-1:0] back_slot, last_slot;
  logic [CW-1:0] count_m1;
  logic [SW:0]   cmp_pos_p1;
  logic          is_full, is_empty;

  logic [SW+POS_W-1:0] pos_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  assign in_accept = start && !busy;
  assign busy      = (state_r != S_IDLE);

  // Ring arithmetic on slot indices, wrapping at DEPTH.
  always_comb begin
    front_dec   = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
    front_inc   = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
    rd_slot_inc = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
    count_m1    = count_r - 1'b1;
    back_sum    = {1'b0, front_r} + {1'b0, count_r[SW-1:0]};
    last_sum    = {1'b0, front_r} + {1'b0, count_m1[SW-1:0]};
    back_slot   = (back_sum >= DEPTH_EXT) ? SW'(back_sum - DEPTH_EXT) : back_sum[SW-1:0];
    last_slot   = (last_sum >= DEPTH_EXT) ? SW'(last_sum - DEPTH_EXT) : last_sum[SW-1:0];
    cmp_pos_p1  = {1'b0, cmp_pos_r} + 1'b1;
    is_full     = (count_r >= FULL_CNT);
    is_empty    = (count_r == '0);
  end

  // Command decode, search sequencing and result selection.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    cmp_pos_nxt    = cmp_pos_r;
    rd_slot_nxt    = rd_slot_inc;
    mem_we         = 1'b0;
    mem_waddr      = back_slot;
    mem_raddr      = rd_slot_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = ST_OK;
    out_data_nxt   = '0;
    out_pos_nxt    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          key_nxt = in_key_value;
          unique case (in_op)
            OP_PUSH_FRONT: begin
              out_strobe_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              out_strobe_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_slot;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                mem_raddr = front_r;
                front_nxt = front_inc;
                count_nxt = count_m1;
                state_nxt = S_POP;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                mem_raddr = last_slot;
                count_nxt = count_m1;
                state_nxt = S_POP;
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_MISS;
              end else begin
                mem_raddr   = front_r;
                rd_slot_nxt = front_inc;
                cmp_pos_nxt = '0;
                state_nxt   = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              out_strobe_nxt = 1'b1;
              front_nxt      = '0;
              count_nxt      = '0;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = mem_rdata;
        state_nxt      = S_IDLE;
      end
      S_SEARCH: begin
        // The entry at cmp_pos_r arrives this cycle; the next one is read.
        cmp_pos_nxt = cmp_pos_p1[SW-1:0];
        if (mem_rdata == key_r) begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = key_r;
          out_pos_nxt    = cmp_pos_r;
          state_nxt      = S_IDLE;
        end else if (cmp_pos_p1 == count_r) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_MISS;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cmp_pos_r    <= cmp_pos_nxt;
    rd_slot_r    <= rd_slot_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= count_nxt;
  end

  // Key store.
  bdq_ram #(
    .DEPTH (DEPTH),
    .AW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (key_nxt),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result beat, position and count kept to their field widths.
  assign pos_ext   = {{POS_W{1'b0}}, out_pos_r};
  assign count_ext = {{COUNT_W{1'b0}}, out_count_r};

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = pos_ext[POS_W-1:0];
  assign out_entry_count    = count_ext[COUNT_W-1:0];

  // The count never exceeds the store depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("deque count exceeds depth");

  // The store is written only when a command is taken in the idle state.
  a_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_accept && state_r == S_IDLE))
    else $error("store written outside an accepted push");

  // A search never compares beyond the last held entry.
  a_search_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> ({1'b0, cmp_pos_r} < count_r))
    else $error("search position beyond held entries");

  // A pop from a non-empty deque passes through the pop state and then strobes its result.
  a_pop_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_POP_FRONT || in_op == OP_POP_BACK) && count_r != '0)
      |=> ##1 out_strobe_r)
    else $error("pop result missing");

  // A push onto a non-full deque raises the count by one.
  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK) && count_r < FULL_CNT)
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not advance the count");

endmodule
